[rtl/core/srg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srg_pkg
// Types, field widths, fixed-point constants and the quarter-wave sine
// generator function shared by the sine reference generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  // Transaction field widths.
  localparam int FIELD_W = 27;   // frequency, amplitude, position
  localparam int VEL_W   = 40;   // velocity, Q24.16

  // Shared multiplier operand and product widths.
  localparam int MA_W   = 28;
  localparam int MB_W   = 33;
  localparam int PROD_W = MA_W + MB_W;

  // Widths of the held intermediate values.
  localparam int TBL_W = 15;     // unsigned quarter-wave entry, Q0.15
  localparam int TRIG_W = 17;    // signed sine or cosine
  localparam int OMEGA_W = 30;   // 2 pi f in Q14.16

  // Command codes.
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Fixed-point constants.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam logic signed [MB_W-1:0] TWO_PI_Q29 = 33'sd3373259426;

  localparam logic signed [PROD_W-1:0] RND_14  = PROD_W'(64'd1 << 14);
  localparam logic signed [PROD_W-1:0] RND_15  = PROD_W'(64'd1 << 15);
  localparam logic signed [PROD_W-1:0] RND_28  = PROD_W'(64'd1 << 28);
  localparam logic signed [PROD_W-1:0] POS_HI  = PROD_W'(64'sd65536000);
  localparam logic signed [PROD_W-1:0] POS_LO  = -PROD_W'(64'sd65536000);
  localparam logic signed [PROD_W-1:0] VEL_HI  = PROD_W'(64'sd549755813887);
  localparam logic signed [PROD_W-1:0] VEL_LO  = -PROD_W'(64'sd549755813888);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RLO,
    S_RHI,
    S_RACC,
    S_PHASE,
    S_RDS,
    S_RDC,
    S_MW,
    S_MP,
    S_MC,
    S_CW,
    S_MV,
    S_FIN
  } srg_state_t;

  // Quarter-wave sine entry sin(pi/2 * a / 2^tab_bits) in Q0.15, built from
  // a Q30 Taylor evaluation in nested form. Only used at elaboration.
  function automatic logic [TBL_W-1:0] quarter_sine(input int unsigned a,
                                                    input int unsigned tab_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    longint unsigned p;
    x  = (HALF_PI_Q30 * longint'(a)) >> tab_bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      p = (x2 * t) >> 30;
      case (i)
        0:       t = Q30_ONE - p / 156;
        1:       t = Q30_ONE - p / 110;
        2:       t = Q30_ONE - p / 72;
        3:       t = Q30_ONE - p / 42;
        4:       t = Q30_ONE - p / 20;
        default: t = Q30_ONE - p / 6;
      endcase
    end
    s = (x * t) >> 30;
    v = (s + (64'd1 << 14)) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[TBL_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/srg_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srg_in_if
// Command channel: a step or clear command with frequency and amplitude.
// ----------------------------------------------------------------------------
interface srg_in_if;
  import srg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [FIELD_W-1:0] frequency_hz;
  logic signed [FIELD_W-1:0] amplitude;

  modport source (output valid, output command, output frequency_hz,
                  output amplitude, input ready);
  modport sink   (input valid, input command, input frequency_hz,
                  input amplitude, output ready);
endinterface
`default_nettype wire

[rtl/core/srg_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srg_out_if
// Result channel: position and velocity of the sine reference.
// ----------------------------------------------------------------------------
interface srg_out_if;
  import srg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] position;
  logic signed [VEL_W-1:0]   velocity;

  modport source (output valid, output position, output velocity, input ready);
  modport sink   (input valid, input position, input velocity, output ready);
endinterface
`default_nettype wire

[rtl/core/sine_reference_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sine_reference_generator
// Direct digital synthesis of a sine position reference and its velocity,
// one result transaction for every command transaction.
// ----------------------------------------------------------------------------
// Usage. Each command transaction on in_ch carries a command, a Q11.16
// frequency and a Q11.16 amplitude. A step command advances the full-turn
// phase accumulator by frequency / TICK_RATE_HZ turns (wrapping modulo one
// turn) and returns amplitude * sin(phase) as position and
// amplitude * cos(phase) * 2 pi f as velocity, both saturated. A clear
// command zeroes the phase and returns a transaction of zeros.
// A step forms the phase increment by reciprocal multiplication on one
// shared 28 x 33 signed multiplier and then updates the phase; a
// registered sine table read and four more products on the same
// multiplier then finish the item. A clear command goes straight to the
// final state, which loads its zero result into the output register.
// in_ch.ready is high only while the sequencer is idle, so one item is
// worked at a time and no new command is taken until the last one has
// left the sequencer.
// The result sits in an output register; the next command may be accepted
// while it waits, and a finished item only holds in its last step while the
// previous result has not been taken. Reset clears the phase and drops any
// pending result.
// ----------------------------------------------------------------------------
module sine_reference_generator #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int TICK_RATE_HZ    = 1000
) (
  input  wire logic clk,
  input  wire logic rst_n,
  srg_in_if.sink    in_ch,
  srg_out_if.source out_ch
);
  import srg_pkg::*;

  // Table covers addresses 0 to 2^TABLE_ADDR_BITS inclusive.
  localparam int ROM_DEPTH = (2 ** TABLE_ADDR_BITS) + 1;
  localparam int ROM_AW    = TABLE_ADDR_BITS + 1;

  // Phase increment by reciprocal multiplication. The dividend
  // |f| * 2^SHIFT + TICK_RATE_HZ / 2 stays below 2^NUM_W, so with
  // REC_FULL = ceil(2^REC_K / TICK_RATE_HZ) the bits of dividend * REC_FULL
  // from REC_K upwards are the exact quotient. Only the low PHASE_BITS bits
  // of the quotient matter, so the product is kept modulo 2^ACC_W.
  localparam int SHIFT = PHASE_BITS - 16;
  localparam int NUM_W = FIELD_W + SHIFT;
  localparam int REC_K = NUM_W + $clog2(TICK_RATE_HZ);
  localparam int ACC_W = REC_K + PHASE_BITS;

  localparam logic [127:0] REC_FULL =
      ((128'd1 << REC_K) + 128'(TICK_RATE_HZ) - 128'd1) / 128'(TICK_RATE_HZ);
  localparam logic [127:0] HALF_REC = 128'(TICK_RATE_HZ / 2) * REC_FULL;

  localparam logic [MB_W-1:0]   REC_LO   = MB_W'(REC_FULL[31:0]);
  localparam logic [MB_W-1:0]   REC_HI   = MB_W'(REC_FULL[63:32]);
  localparam logic [ACC_W-1:0]  ACC_INIT = ACC_W'(HALF_REC);
  localparam logic [ROM_AW-1:0] ROM_TOP  = ROM_AW'(2 ** TABLE_ADDR_BITS);

  typedef logic [TBL_W-1:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      r[i] = quarter_sine(i, TABLE_ADDR_BITS);
    end
    return r;
  endfunction

  localparam rom_t SINE_TBL = build_rom();

  // Control state.
  srg_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;

  // Datapath registers.
  logic                        clr_r, clr_nxt;
  logic                        neg_r, neg_nxt;
  logic signed [FIELD_W-1:0]   freq_r, freq_nxt;
  logic signed [FIELD_W-1:0]   amp_r, amp_nxt;
  logic [FIELD_W-1:0]          fmag_r, fmag_nxt;
  logic [ACC_W-1:0]            acc_r, acc_nxt;
  logic [TBL_W-1:0]            rom_q_r;
  logic signed [TRIG_W-1:0]    sin_r, sin_nxt;
  logic signed [TRIG_W-1:0]    cos_r, cos_nxt;
  logic signed [OMEGA_W-1:0]   w_r, w_nxt;
  logic signed [MA_W-1:0]      c_r, c_nxt;
  logic signed [FIELD_W-1:0]   pos_r, pos_nxt;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [FIELD_W-1:0]   out_pos_r, out_pos_nxt;
  logic signed [VEL_W-1:0]     out_vel_r, out_vel_nxt;

  // Combinational helpers.
  logic [1:0]                  quad;
  logic [TABLE_ADDR_BITS-1:0]  tbl_a;
  logic [ROM_AW-1:0]           sin_addr;
  logic [ROM_AW-1:0]           cos_addr;
  logic [ROM_AW-1:0]           rom_addr;
  logic signed [TRIG_W-1:0]    rom_val;
  logic [FIELD_W-1:0]          fmag;
  logic [PHASE_BITS-1:0]       step_inc;
  logic                        mul_en;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]    rnd15_q;
  logic signed [PROD_W-1:0]    rnd29_q;
  logic signed [PROD_W-1:0]    rnd16_q;
  logic signed [PROD_W-1:0]    pos_sat;
  logic signed [PROD_W-1:0]    vel_sat;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.velocity = out_vel_r;

  // Quadrant and table address of the current phase. The second quadrant
  // and the fourth read the table mirrored; cosine reads the other mirror.
  assign quad     = phase_r[PHASE_BITS-1 -: 2];
  assign tbl_a    = phase_r[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign sin_addr = quad[0] ? (ROM_TOP - ROM_AW'(tbl_a)) : ROM_AW'(tbl_a);
  assign cos_addr = quad[0] ? ROM_AW'(tbl_a) : (ROM_TOP - ROM_AW'(tbl_a));
  assign rom_addr = (state_r == S_RDS) ? sin_addr : cos_addr;
  assign rom_val  = TRIG_W'({2'b00, rom_q_r});

  // Magnitude of the incoming frequency; the most negative value maps to 2^26.
  assign fmag = in_ch.frequency_hz[FIELD_W-1]
              ? (~FIELD_W'(in_ch.frequency_hz) + FIELD_W'(1))
              : FIELD_W'(in_ch.frequency_hz);

  // Rounded phase increment, taken from the top of the reciprocal product.
  assign step_inc = acc_r[REC_K +: PHASE_BITS];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_RLO: begin
        mul_a = MA_W'(fmag_r);
        mul_b = REC_LO;
      end
      S_RHI: begin
        mul_a = MA_W'(fmag_r);
        mul_b = REC_HI;
      end
      S_MW: begin
        mul_a = MA_W'(freq_r);
        mul_b = TWO_PI_Q29;
      end
      S_MP: begin
        mul_a = MA_W'(amp_r);
        mul_b = MB_W'(sin_r);
      end
      S_MC: begin
        mul_a = MA_W'(amp_r);
        mul_b = MB_W'(cos_r);
      end
      S_MV: begin
        mul_a = c_r;
        mul_b = MB_W'(w_r);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Rounded, floored scalings of the registered product.
  assign rnd15_q = (prod_r + RND_14) >>> 15;
  assign rnd29_q = (prod_r + RND_28) >>> 29;
  assign rnd16_q = (prod_r + RND_15) >>> 16;
  assign pos_sat = (rnd15_q > POS_HI) ? POS_HI : ((rnd15_q < POS_LO) ? POS_LO : rnd15_q);
  assign vel_sat = (rnd16_q > VEL_HI) ? VEL_HI : ((rnd16_q < VEL_LO) ? VEL_LO : rnd16_q);

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    clr_nxt       = clr_r;
    neg_nxt       = neg_r;
    freq_nxt      = freq_r;
    amp_nxt       = amp_r;
    fmag_nxt      = fmag_r;
    acc_nxt       = acc_r;
    sin_nxt       = sin_r;
    cos_nxt       = cos_r;
    w_nxt         = w_r;
    c_nxt         = c_r;
    pos_nxt       = pos_r;
    prod_nxt      = mul_en ? (mul_a * mul_b) : prod_r;
    out_pos_nxt   = out_pos_r;
    out_vel_nxt   = out_vel_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          freq_nxt = in_ch.frequency_hz;
          amp_nxt  = in_ch.amplitude;
          if (in_ch.command == CMD_CLEAR) begin
            phase_nxt = '0;
            clr_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            clr_nxt   = 1'b0;
            neg_nxt   = in_ch.frequency_hz[FIELD_W-1];
            fmag_nxt  = fmag;
            state_nxt = S_RLO;
          end
        end
      end
      S_RLO: begin
        state_nxt = S_RHI;
      end
      S_RHI: begin
        // Low half of the reciprocal product, scaled, plus the rounding term.
        acc_nxt   = (ACC_W'(prod_r) << SHIFT) + ACC_INIT;
        state_nxt = S_RACC;
      end
      S_RACC: begin
        acc_nxt   = acc_r + (ACC_W'(prod_r) << (SHIFT + 32));
        state_nxt = S_PHASE;
      end
      S_PHASE: begin
        phase_nxt = neg_r ? (phase_r - step_inc) : (phase_r + step_inc);
        state_nxt = S_RDS;
      end
      S_RDS: begin
        state_nxt = S_RDC;
      end
      S_RDC: begin
        sin_nxt   = quad[1] ? -rom_val : rom_val;
        state_nxt = S_MW;
      end
      S_MW: begin
        cos_nxt   = (quad[1] ^ quad[0]) ? -rom_val : rom_val;
        state_nxt = S_MP;
      end
      S_MP: begin
        w_nxt     = rnd29_q[OMEGA_W-1:0];
        state_nxt = S_MC;
      end
      S_MC: begin
        pos_nxt   = pos_sat[FIELD_W-1:0];
        state_nxt = S_CW;
      end
      S_CW: begin
        c_nxt     = rnd15_q[MA_W-1:0];
        state_nxt = S_MV;
      end
      S_MV: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Load the output register once the previous result has gone.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = clr_r ? '0 : pos_r;
          out_vel_nxt   = clr_r ? '0 : vel_sat[VEL_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_r     <= clr_nxt;
    neg_r     <= neg_nxt;
    freq_r    <= freq_nxt;
    amp_r     <= amp_nxt;
    fmag_r    <= fmag_nxt;
    acc_r     <= acc_nxt;
    rom_q_r   <= SINE_TBL[rom_addr];
    sin_r     <= sin_nxt;
    cos_r     <= cos_nxt;
    w_r       <= w_nxt;
    c_r       <= c_nxt;
    pos_r     <= pos_nxt;
    prod_r    <= prod_nxt;
    out_pos_r <= out_pos_nxt;
    out_vel_r <= out_vel_nxt;
  end

endmodule
`default_nettype wire
